/* rtl/smue_pkg.sv */
// Shared types and constants for the SOM U-matrix engine.
package smue_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_VECTOR_LENGTH = 2'd2;
    localparam logic [1:0] REG_WRAP_MODE     = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [4:0] node_x;
        logic [4:0] node_y;
        logic [3:0] dim_index;
        logic [15:0] weight_value;
    } t_in_item;

    typedef struct packed {
        logic [17:0] u_value;
        logic        no_neighbours;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [5:0]  data;
    } t_cfg_item;

    // controller -> datapath commands
    typedef struct packed {
        logic       wr_en;       // store the input weight
        logic       load_item;   // capture query coordinates
        logic       neigh_init;  // start neighbour scan
        logic       neigh_next;  // advance neighbour candidate
        logic       dim_clear;   // clear accumulator and dim counter
        logic       rd_issue;    // issue read of both weights for current dim
        logic       acc_step;    // accumulate squared difference
        logic       sqrt_start;
        logic       sqrt_step;
        logic       sum_add;     // add root to total, bump count
        logic       div_start;
        logic       div_step;
        logic       out_load;
    } t_ctrl;

    // datapath -> controller status
    typedef struct packed {
        logic in_map;
        logic neigh_valid;   // current candidate counts
        logic neigh_done;    // candidate list exhausted
        logic dim_last;
        logic sqrt_done;
        logic div_done;
    } t_stat;
endpackage

/* rtl/smue_if.sv */
// Valid/ready channel interfaces.
interface smue_in_if;
    logic                 valid;
    logic                 ready;
    smue_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smue_out_if;
    logic                 valid;
    logic                 ready;
    smue_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smue_cfg_if;
    logic                 valid;
    logic                 ready;
    smue_pkg::t_cfg_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/som_u_matrix_engine.sv */
// Top level of the SOM U-matrix engine.
// A write item is stored directly from idle. A query tests the nine 3x3
// offsets one at a time, then sees the end of the list, and for each neighbour
// reads both weights of each dimension from the single-port codebook and
// multiply-accumulates them, then takes a one-bit-per-cycle square root and
// adds the root to the total; the mean is then formed by the divider. The next
// item is taken only once the result has been accepted and the controller is
// idle again. The codebook is not cleared after reset; read only nodes already
// written.
module som_u_matrix_engine #(
    parameter int MAX_MAP_WIDTH  = 32,
    parameter int MAX_MAP_HEIGHT = 32,
    parameter int MAX_DIMENSIONS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    smue_in_if.sink    in_ch,
    smue_out_if.source out_ch,
    smue_cfg_if.sink   cfg_ch
);
    smue_pkg::t_ctrl ctrl;
    smue_pkg::t_stat stat;

    assign cfg_ch.ready = 1'b1;

    smue_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_cmd    (in_ch.data.cmd),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    smue_datapath #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
        .MAX_DIMENSIONS (MAX_DIMENSIONS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .o_stat   (stat),
        .i_item   (in_ch.data),
        .i_cfg    (cfg_ch.data),
        .i_cfg_we (cfg_ch.valid),
        .o_result (out_ch.data)
    );
endmodule

/* rtl/smue_ctrl.sv */
// Sequencing state machine for writes and U-matrix queries.
module smue_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  smue_pkg::t_stat  i_stat,
    output smue_pkg::t_ctrl  o_ctrl
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DIMRD, S_DIMWAIT, S_ACC, S_SQRT, S_SUM,
        S_DIV, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_ctrl      = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in_cmd == smue_pkg::CMD_WRITE) begin
                        o_ctrl.wr_en = 1'b1;
                    end else begin
                        o_ctrl.load_item = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // candidate coordinates register here; test them
                if (!i_stat.in_map || i_stat.neigh_done) begin
                    o_ctrl.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (i_stat.neigh_valid) begin
                    o_ctrl.dim_clear = 1'b1;
                    n_state = S_DIMRD;
                end else begin
                    o_ctrl.neigh_next = 1'b1;
                end
            end
            S_DIMRD: begin
                o_ctrl.rd_issue = 1'b1;
                n_state = S_DIMWAIT;
            end
            S_DIMWAIT: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_ctrl.acc_step = 1'b1;
                if (i_stat.dim_last) begin
                    o_ctrl.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_DIMRD;
                end
            end
            S_SQRT: begin
                if (i_stat.sqrt_done) n_state = S_SUM;
                else o_ctrl.sqrt_step = 1'b1;
            end
            S_SUM: begin
                o_ctrl.sum_add    = 1'b1;
                o_ctrl.neigh_next = 1'b1;
                n_state = S_SCAN;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_ctrl.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_ctrl.div_step = 1'b1;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_IDLE) o_ctrl.neigh_init = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* rtl/smue_datapath.sv */
// Codebook memory, neighbour walk, squared-distance accumulate, root and mean.
module smue_datapath #(
    parameter int MAX_MAP_WIDTH  = 32,
    parameter int MAX_MAP_HEIGHT = 32,
    parameter int MAX_DIMENSIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smue_pkg::t_ctrl     i_ctrl,
    output smue_pkg::t_stat     o_stat,
    input  smue_pkg::t_in_item  i_item,
    input  smue_pkg::t_cfg_item i_cfg,
    input  logic                i_cfg_we,
    output smue_pkg::t_out_item o_result
);
    localparam int DW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT * MAX_DIMENSIONS;
    localparam int AW = $clog2(DEPTH);
    // room for MAX_DIMENSIONS squared differences, kept even for the root
    localparam int ACCW = (DW % 2 == 0) ? 34 + DW : 35 + DW;
    localparam int RW = ACCW / 2;
    localparam int TOTW = RW + 4;

    // configuration, clamped on the fly
    logic [5:0] r_map_width, r_map_height;
    logic [4:0] r_vector_length;
    logic       r_wrap_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= 6'd1;
            r_map_height    <= 6'd1;
            r_vector_length <= 5'd1;
            r_wrap_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg.index)
                smue_pkg::REG_MAP_WIDTH:     r_map_width     <= i_cfg.data;
                smue_pkg::REG_MAP_HEIGHT:    r_map_height    <= i_cfg.data;
                smue_pkg::REG_VECTOR_LENGTH: r_vector_length <= i_cfg.data[4:0];
                smue_pkg::REG_WRAP_MODE:     r_wrap_mode     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    logic [8:0] w_eff, h_eff, len_eff;
    always_comb begin
        w_eff = (r_map_width == '0) ? 9'd1 :
                ({3'd0, r_map_width} > 9'(MAX_MAP_WIDTH)) ? 9'(MAX_MAP_WIDTH)
                : {3'd0, r_map_width};
        h_eff = (r_map_height == '0) ? 9'd1 :
                ({3'd0, r_map_height} > 9'(MAX_MAP_HEIGHT)) ? 9'(MAX_MAP_HEIGHT)
                : {3'd0, r_map_height};
        len_eff = (r_vector_length == '0) ? 9'd1 :
                ({4'd0, r_vector_length} > 9'(MAX_DIMENSIONS)) ? 9'(MAX_DIMENSIONS)
                : {4'd0, r_vector_length};
    end

    // codebook memory
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_a, r_rd_b;
    logic        r_rd_sel;

    function automatic logic [AW-1:0] addr_of(input logic [8:0] x, input logic [8:0] y,
                                             input logic [8:0] d);
        logic [AW+10:0] a;
        a = ((AW+11)'(y) * (AW+11)'(MAX_MAP_WIDTH) + (AW+11)'(x))
            * (AW+11)'(MAX_DIMENSIONS) + (AW+11)'(d);
        return a[AW-1:0];
    endfunction

    logic wr_ok;
    assign wr_ok = (32'(i_item.node_x) < MAX_MAP_WIDTH) &&
                   (32'(i_item.node_y) < MAX_MAP_HEIGHT) &&
                   (32'(i_item.dim_index) < MAX_DIMENSIONS);

    // query state
    logic [8:0] r_qx, r_qy, r_cx, r_cy, r_dim;
    logic [3:0] r_cand;     // 0..8 over the 3x3 offsets, 9 once exhausted
    logic [ACCW-1:0] r_acc;
    logic [TOTW-1:0] r_total;
    logic [3:0] r_count;
    logic [AW-1:0] rd_addr;

    // read the node weight on issue, the neighbour weight in the cycle after
    always_comb begin
        if (i_ctrl.rd_issue) rd_addr = addr_of(r_qx, r_qy, r_dim);
        else                 rd_addr = addr_of(r_cx, r_cy, r_dim);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && wr_ok)
            r_mem[addr_of(9'(i_item.node_x), 9'(i_item.node_y), 9'(i_item.dim_index))]
                <= i_item.weight_value;
        if (i_ctrl.rd_issue) r_rd_a <= r_mem[rd_addr];
        else if (r_rd_sel)   r_rd_b <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_sel <= 1'b0;
        end else begin
            r_rd_sel <= i_ctrl.rd_issue;
        end
    end

    // candidate from offset index: dx,dy in {-1,0,1}
    logic [8:0] cand_x, cand_y;
    logic [1:0] ox, oy;
    logic       x_ok, y_ok, dup;
    always_comb begin
        case (r_cand)
            4'd0:    {oy, ox} = {2'd0, 2'd0};
            4'd1:    {oy, ox} = {2'd0, 2'd1};
            4'd2:    {oy, ox} = {2'd0, 2'd2};
            4'd3:    {oy, ox} = {2'd1, 2'd0};
            4'd5:    {oy, ox} = {2'd1, 2'd2};
            4'd6:    {oy, ox} = {2'd2, 2'd0};
            4'd7:    {oy, ox} = {2'd2, 2'd1};
            4'd8:    {oy, ox} = {2'd2, 2'd2};
            default: {oy, ox} = {2'd1, 2'd1};
        endcase
        x_ok = 1'b1;
        y_ok = 1'b1;
        cand_x = r_qx;
        cand_y = r_qy;
        case (ox)
            2'd0: begin
                if (r_qx != 9'd0) cand_x = r_qx - 9'd1;
                else if (r_wrap_mode) cand_x = w_eff - 9'd1;
                else x_ok = 1'b0;
            end
            2'd2: begin
                if (r_qx + 9'd1 < w_eff) cand_x = r_qx + 9'd1;
                else if (r_wrap_mode) cand_x = 9'd0;
                else x_ok = 1'b0;
            end
            default: cand_x = r_qx;
        endcase
        case (oy)
            2'd0: begin
                if (r_qy != 9'd0) cand_y = r_qy - 9'd1;
                else if (r_wrap_mode) cand_y = h_eff - 9'd1;
                else y_ok = 1'b0;
            end
            2'd2: begin
                if (r_qy + 9'd1 < h_eff) cand_y = r_qy + 9'd1;
                else if (r_wrap_mode) cand_y = 9'd0;
                else y_ok = 1'b0;
            end
            default: cand_y = r_qy;
        endcase
        // drop repeats: the centre offset, and under wrap an offset on the node or on another offset's node
        dup = 1'b0;
        if (r_wrap_mode && ox == 2'd2 && w_eff <= 9'd2) dup = 1'b1;
        if (r_wrap_mode && oy == 2'd2 && h_eff <= 9'd2) dup = 1'b1;
        if (r_wrap_mode && ox == 2'd0 && w_eff == 9'd1) dup = 1'b1;
        if (r_wrap_mode && oy == 2'd0 && h_eff == 9'd1) dup = 1'b1;
        if (ox == 2'd1 && oy == 2'd1) dup = 1'b1;
    end

    assign o_stat.in_map      = (r_qx < w_eff) && (r_qy < h_eff);
    assign o_stat.neigh_done  = (r_cand == 4'd9);
    assign o_stat.neigh_valid = x_ok && y_ok && !dup;
    assign o_stat.dim_last    = (r_dim + 9'd1 >= len_eff);

    logic signed [16:0] diff;
    logic [16:0] adiff;
    logic [33:0] sq;
    assign diff  = 17'($signed(r_rd_a)) - 17'($signed(r_rd_b));
    assign adiff = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq    = adiff * adiff;

    // bit-serial integer square root, one result bit per cycle
    logic [ACCW-1:0] r_sq_v, r_sq_r, r_sq_bit;
    logic [ACCW-1:0] sq_sum;
    assign sq_sum = r_sq_r + r_sq_bit;
    assign o_stat.sqrt_done = (r_sq_bit == '0);

    // restoring divider of the total by the count
    logic [TOTW-1:0] r_quo;
    logic [TOTW+3:0] r_rem;
    logic [5:0]      r_div_cnt;
    logic [TOTW+3:0] rem_sh;
    assign rem_sh = {r_rem[TOTW+2:0], r_quo[TOTW-1]};
    assign o_stat.div_done = (r_div_cnt == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand    <= 4'd0;
            r_div_cnt <= 6'd0;
            r_sq_bit  <= '0;
        end else begin
            if (i_ctrl.load_item) begin
                r_qx    <= 9'(i_item.node_x);
                r_qy    <= 9'(i_item.node_y);
                r_total <= '0;
                r_count <= 4'd0;
            end
            if (i_ctrl.neigh_init) r_cand <= 4'd0;
            else if (i_ctrl.neigh_next) r_cand <= r_cand + 4'd1;
            if (i_ctrl.dim_clear) begin
                r_dim <= 9'd0;
                r_acc <= '0;
                r_cx  <= cand_x;
                r_cy  <= cand_y;
            end else if (i_ctrl.acc_step) begin
                r_acc <= r_acc + ACCW'(sq);
                r_dim <= r_dim + 9'd1;
            end
            if (i_ctrl.sqrt_start) begin
                r_sq_v   <= r_acc + ACCW'(sq);
                r_sq_r   <= '0;
                r_sq_bit <= ACCW'(1) << (ACCW - 2);
            end else if (i_ctrl.sqrt_step) begin
                if (r_sq_v >= sq_sum) begin
                    r_sq_v <= r_sq_v - sq_sum;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            if (i_ctrl.sum_add) begin
                r_total <= r_total + TOTW'(r_sq_r);
                r_count <= r_count + 4'd1;
            end
            if (i_ctrl.div_start) begin
                r_quo     <= r_total;
                r_rem     <= '0;
                r_div_cnt <= (r_count == 4'd0) ? 6'd0 : 6'(TOTW);
            end else if (i_ctrl.div_step) begin
                if (rem_sh >= (TOTW+4)'(r_count)) begin
                    r_rem <= rem_sh - (TOTW+4)'(r_count);
                    r_quo <= {r_quo[TOTW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[TOTW-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt - 6'd1;
            end
            if (i_ctrl.out_load) begin
                o_result.no_neighbours <= (r_count == 4'd0);
                o_result.u_value       <= (r_count == 4'd0) ? 18'd0 : r_quo[17:0];
            end
        end
    end
endmodule
